@@ sv/brs_pkg.sv @@
// brs_pkg: opcodes, status codes, shared types for the bytecode register ALU.
// No dependencies.
package brs_pkg;

   localparam int unsigned WordWidth = 64;

   typedef enum logic [7:0] {
      OP_LDCONST = 8'd0, OP_LDLOCAL = 8'd1, OP_ADD  = 8'd2,  OP_SUB  = 8'd3,
      OP_MUL   = 8'd4,  OP_DIV   = 8'd6,  OP_MOD  = 8'd8,  OP_NOT  = 8'd9,
      OP_AND   = 8'd10, OP_NAND  = 8'd11, OP_OR   = 8'd12, OP_NOR  = 8'd13,
      OP_XOR   = 8'd14, OP_XNOR  = 8'd15, OP_SHL  = 8'd16, OP_SAR  = 8'd17,
      OP_EXIT  = 8'd19
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_EXIT = 3'd1, ST_ILLEGAL = 3'd2,
      ST_BADREG = 3'd3, ST_DIVZERO = 3'd4, ST_HALTED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      K_MUL = 2'd0, K_DIV = 2'd1, K_MOD = 2'd2, K_SHIFT = 2'd3
   } serial_kind_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0, S_RUN = 2'd1, S_FIX = 2'd2, S_OUT = 2'd3
   } state_type;

   // start command to the bit-serial unit
   typedef struct packed {
      logic            start;
      serial_kind_type kind;
      logic            right;   // shift direction for K_SHIFT
   } serial_cmd_type;

endpackage

@@ sv/bytecode_register_alu_step.sv @@
// bytecode_register_alu_step: top level, decode, register file, control sequencer.
// Depends on brs_pkg and brs_serial.
//
// Usage: one 32-bit instruction per req_ transfer, with the load-local value
// alongside. Exactly one result per instruction leaves on rsp_.
// Plain ops (load, add, sub, bitwise, errors, exit, halted) pass from accept
// through S_FIX to S_OUT, where rsp_tvalid rises. Multiply, divide and modulo
// run through the bit-serial unit in S_RUN, one bit per cycle; shifts run
// through it for the shift amount. The bit-serial loop sets the worst case.
// One instruction is in flight at a time; req_tready is high only when idle.
// Reset (synchronous, active high) clears the four registers and the halted
// flag. After exit every instruction answers "halted" and changes nothing.
// When the receiver stalls the result holds in the output register and no
// new instruction is taken until that transfer completes.
module bytecode_register_alu_step
   import brs_pkg::*;
#(
   parameter int unsigned REG_COUNT = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // [31:0] instruction, [95:32] local_value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata    // [2:0] status, [3] wrote, [11:4] dest_index,
                                     // [75:12] written_value, [79:76] zero
);
   localparam int unsigned IdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam logic [WordWidth-1:0] Sign = {1'b1, {(WordWidth-1){1'b0}}};

   state_type            state_ff, state_in;
   logic [WordWidth-1:0] regs_ff [REG_COUNT];
   logic                 halted_ff, halted_in;
   logic [7:0]           op_ff, a_ff;
   logic [WordWidth-1:0] x_ff, y_ff, res_ff, res_in;
   logic                 negq_ff, negr_ff;
   logic [2:0]           st_ff, st_in;
   logic                 wr_ff, wr_in;
   logic                 busy_serial;

   // decode of the incoming transfer
   logic [31:0]          ins;
   logic [7:0]           op, fa, fb, fc;
   logic                 legal, uses_b, uses_c, badreg;
   logic [WordWidth-1:0] xv, yv;
   serial_cmd_type       cmd;
   logic                 sdone;
   logic [WordWidth-1:0] sres, sx, sy;
   logic                 accept;

   assign ins    = req_tdata[31:0];
   assign op     = ins[31:24];
   assign fa     = ins[23:16];
   assign fb     = ins[15:8];
   assign fc     = ins[7:0];
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      legal = 1'b1; uses_b = 1'b0; uses_c = 1'b0;
      case (op)
         OP_LDCONST, OP_LDLOCAL: ;
         OP_NOT: uses_b = 1'b1;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_NAND, OP_OR,
         OP_NOR, OP_XOR, OP_XNOR, OP_SHL, OP_SAR: begin
            uses_b = 1'b1; uses_c = 1'b1;
         end
         default: legal = 1'b0;
      endcase
      badreg = (32'(fa) >= REG_COUNT) || (uses_b && 32'(fb) >= REG_COUNT)
            || (uses_c && 32'(fc) >= REG_COUNT);
      xv = (uses_b && !badreg) ? regs_ff[fb[IdxW-1:0]] : '0;
      yv = (uses_c && !badreg) ? regs_ff[fc[IdxW-1:0]] : '0;
   end

   function automatic logic [WordWidth-1:0] mag(input logic [WordWidth-1:0] v);
      return v[WordWidth-1] ? (~v + 1'b1) : v;
   endfunction

   assign sx = (op_ff == OP_DIV || op_ff == OP_MOD) ? mag(x_ff) : x_ff;
   assign sy = (op_ff == OP_DIV || op_ff == OP_MOD) ? mag(y_ff) : y_ff;

   always_comb begin
      state_in  = state_ff;
      halted_in = halted_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      wr_in     = wr_ff;
      busy_serial = 1'b0;
      case (state_ff)
         S_IDLE: if (accept) begin
            state_in = S_FIX;
            wr_in    = 1'b0;
            res_in   = '0;
            st_in    = ST_OK;
            if (halted_ff)             st_in = ST_HALTED;
            else if (op == OP_EXIT) begin
               st_in = ST_EXIT; halted_in = 1'b1;
            end
            else if (!legal)           st_in = ST_ILLEGAL;
            else if (badreg)           st_in = ST_BADREG;
            else if ((op == OP_DIV || op == OP_MOD) && yv == '0) st_in = ST_DIVZERO;
            else begin
               wr_in = 1'b1;
               case (op)
                  OP_LDCONST: res_in = WordWidth'(fb);
                  OP_LDLOCAL: res_in = req_tdata[95:32];
                  OP_ADD:   res_in = xv + yv;
                  OP_SUB:   res_in = xv - yv;
                  OP_NOT:   res_in = ~xv;
                  OP_AND:   res_in = xv & yv;
                  OP_NAND:  res_in = ~(xv & yv);
                  OP_OR:    res_in = xv | yv;
                  OP_NOR:   res_in = ~(xv | yv);
                  OP_XOR:   res_in = xv ^ yv;
                  OP_XNOR:  res_in = ~(xv ^ yv);
                  default:  state_in = S_RUN;   // mul, div, mod, shifts
               endcase
            end
         end
         S_RUN: begin
            // first cycle issues the start, later cycles wait on done
            busy_serial = 1'b1;
            if (sdone) begin
               res_in = sres;
               if (op_ff == OP_DIV && negq_ff) res_in = ~sres + 1'b1;
               if (op_ff == OP_MOD && negr_ff) res_in = ~sres + 1'b1;
               state_in = S_FIX;
            end
         end
         S_FIX: state_in = S_OUT;
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // start pulse on the first cycle of S_RUN
   logic started_ff;
   always_comb begin
      cmd.start = busy_serial && !started_ff;
      case (op_ff)
         OP_MUL:  cmd.kind = K_MUL;
         OP_DIV:  cmd.kind = K_DIV;
         OP_MOD:  cmd.kind = K_MOD;
         default: cmd.kind = K_SHIFT;
      endcase
      cmd.right = (op_ff == OP_SAR);
   end

   brs_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .op_x   (sx),
      .op_y   (sy),
      .done   (sdone),
      .result (sres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         halted_ff  <= 1'b0;
         started_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= '0;
      end else begin
         state_ff   <= state_in;
         halted_ff  <= halted_in;
         started_ff <= busy_serial && !sdone;
         // plain ops write at the accept edge, before a_ff holds the index
         if (state_ff != S_FIX && state_in == S_FIX && wr_in)
            regs_ff[(state_ff == S_IDLE) ? fa[IdxW-1:0] : a_ff[IdxW-1:0]] <= res_in;
      end
      if (accept) begin
         op_ff   <= op;
         x_ff    <= xv;
         y_ff    <= (op == OP_SHL || op == OP_SAR) ? {58'd0, yv[5:0]} : yv;
         negq_ff <= ((xv ^ yv) & Sign) != '0;
         negr_ff <= xv[WordWidth-1];
      end
      if (state_ff == S_IDLE) a_ff <= fa;
      res_ff <= res_in;
      st_ff  <= st_in;
      wr_ff  <= wr_in;
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {4'd0, wr_ff ? res_ff : 64'd0, wr_ff ? a_ff : 8'd0, wr_ff, st_ff};

   a_one_job: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready) else $error("second accept in flight");
   a_wrote_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && wr_ff |-> st_ff == ST_OK) else $error("write with error status");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halted cleared");
   a_halted_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == ST_HALTED |-> !wr_ff) else $error("write while halted");
endmodule

@@ sv/brs_serial.sv @@
// brs_serial: bit-serial multiply, unsigned divide/modulo and shift, one bit per cycle.
// Depends on brs_pkg.
module brs_serial
   import brs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  serial_cmd_type       cmd,
   input  logic [WordWidth-1:0] op_x,     // multiplicand / dividend mag / shift value
   input  logic [WordWidth-1:0] op_y,     // multiplier / divisor mag / shift amount
   output logic                 done,
   output logic [WordWidth-1:0] result
);
   localparam int unsigned CntW = $clog2(WordWidth + 1);

   logic                 busy_ff, busy_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   serial_kind_type      kind_ff, kind_in;
   logic                 right_ff, right_in;
   logic [WordWidth-1:0] acc_ff, acc_in;   // product / remainder
   logic [WordWidth-1:0] sh_ff, sh_in;     // multiplicand, dividend/quotient, shift value
   logic [WordWidth-1:0] y_ff, y_in;       // multiplier bits or divisor
   logic [WordWidth:0]   rem_sh;
   logic [WordWidth:0]   rem_sub;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      right_in = right_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      y_in     = y_ff;
      rem_sh   = {acc_ff, sh_ff[WordWidth-1]};
      rem_sub  = rem_sh - {1'b0, y_ff};
      done     = 1'b0;
      if (cmd.start) begin
         busy_in  = 1'b1;
         kind_in  = cmd.kind;
         right_in = cmd.right;
         acc_in   = '0;
         sh_in    = op_x;
         y_in     = op_y;
         cnt_in   = (cmd.kind == K_SHIFT) ? CntW'(op_y[5:0]) : CntW'(WordWidth);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            case (kind_ff)
               K_MUL: begin
                  if (y_ff[0]) acc_in = acc_ff + sh_ff;
                  sh_in = {sh_ff[WordWidth-2:0], 1'b0};
                  y_in  = {1'b0, y_ff[WordWidth-1:1]};
               end
               K_DIV, K_MOD: begin
                  if (!rem_sub[WordWidth]) begin
                     acc_in = rem_sub[WordWidth-1:0];
                     sh_in  = {sh_ff[WordWidth-2:0], 1'b1};
                  end else begin
                     acc_in = rem_sh[WordWidth-1:0];
                     sh_in  = {sh_ff[WordWidth-2:0], 1'b0};
                  end
               end
               K_SHIFT: begin
                  sh_in = right_ff ? {sh_ff[WordWidth-1], sh_ff[WordWidth-1:1]}
                                   : {sh_ff[WordWidth-2:0], 1'b0};
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (kind_ff)
         K_MUL, K_MOD: result = acc_ff;
         default:      result = sh_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      kind_ff  <= kind_in;
      right_ff <= right_in;
      acc_ff   <= acc_in;
      sh_ff    <= sh_in;
      y_ff     <= y_in;
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff && cnt_ff == '0) else $error("done without busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("start while busy");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(WordWidth)) else $error("count overrun");
endmodule

@@ tb/bytecode_register_alu_step_checker.sv @@
// Checker for bytecode_register_alu_step: watches req_/rsp_ transfers, predicts results.
// Depends on brs_pkg.
module bytecode_register_alu_step_checker
   import brs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   localparam int unsigned RegCount = 4;
   localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

   logic [63:0] regs [RegCount];
   logic        halted;
   logic [79:0] expected_results [$];

   function automatic logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   // Executes one instruction on the model state, returns the packed result.
   function automatic logic [79:0] execute(logic [31:0] ins, logic [63:0] loc);
      logic [7:0]  op, a, b, c;
      logic        use_b, use_c, legal;
      logic [63:0] x, y, r, q;
      status_type  st;
      op = ins[31:24]; a = ins[23:16]; b = ins[15:8]; c = ins[7:0];
      use_b = 0; use_c = 0; legal = 1; r = '0;
      if (halted) return {76'd0, 1'b0, ST_HALTED};
      if (op == OP_EXIT) begin
         halted = 1;
         return {76'd0, 1'b0, ST_EXIT};
      end
      case (op)
         OP_LDCONST, OP_LDLOCAL: ;
         OP_NOT: use_b = 1;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_NAND, OP_OR, OP_NOR,
         OP_XOR, OP_XNOR, OP_SHL, OP_SAR: begin
            use_b = 1; use_c = 1;
         end
         default: legal = 0;
      endcase
      if (!legal) return {76'd0, 1'b0, ST_ILLEGAL};
      if (a >= RegCount || (use_b && b >= RegCount) || (use_c && c >= RegCount))
         return {76'd0, 1'b0, ST_BADREG};
      x = use_b ? regs[b[1:0]] : '0;
      y = use_c ? regs[c[1:0]] : '0;
      if ((op == OP_DIV || op == OP_MOD) && y == 0) return {76'd0, 1'b0, ST_DIVZERO};
      case (op)
         OP_LDCONST: r = {56'd0, b};
         OP_LDLOCAL: r = loc;
         OP_ADD:   r = x + y;
         OP_SUB:   r = x - y;
         OP_MUL:   r = x * y;
         OP_DIV: begin
            q = mag(x) / mag(y);
            r = ((x ^ y) & SignBit) != 0 ? -q : q;
         end
         OP_MOD: begin
            q = mag(x) % mag(y);
            r = x[63] ? -q : q;
         end
         OP_NOT:  r = ~x;
         OP_AND:  r = x & y;
         OP_NAND: r = ~(x & y);
         OP_OR:   r = x | y;
         OP_NOR:  r = ~(x | y);
         OP_XOR:  r = x ^ y;
         OP_XNOR: r = ~(x ^ y);
         OP_SHL:  r = x << y[5:0];
         OP_SAR:  r = $signed(x) >>> y[5:0];
         default: ;
      endcase
      regs[a[1:0]] = r;
      return {4'd0, r, a, 1'b1, ST_OK};
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      logic [79:0] want;
      if (reset) begin
         for (int i = 0; i < RegCount; i++) regs[i] = '0;
         halted = 0;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(execute(req_tdata[31:0], req_tdata[95:32]));
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_tdata) begin
                  if (fail_count < 10)
                     $display("mismatch: status %0d/%0d wrote %0d/%0d dest %0d/%0d value %h/%h",
                              want[2:0], rsp_tdata[2:0], want[3], rsp_tdata[3],
                              want[11:4], rsp_tdata[11:4], want[75:12], rsp_tdata[75:12]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ tb/bytecode_register_alu_step_test.sv @@
// Testbench top for bytecode_register_alu_step: clock, reset, stimulus, verdict.
// Depends on brs_pkg, the block and bytecode_register_alu_step_checker.
module bytecode_register_alu_step_test;
   import brs_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;
   int          fail_count, pending_count, result_count;
   int          idle_pct = 35;    // idling chance, both sides
   bit          hold_off = 0;     // receiver long stall request
   int          sent_count = 0;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   bytecode_register_alu_step i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   bytecode_register_alu_step_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_count, .pending_count, .result_count
   );

   // receiver: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off) begin
         rsp_tready <= 0;
         repeat (400) @(posedge clock);
         hold_off = 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= idle_pct;
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || hold_off)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WatchdogLimit) begin
         $display("watchdog timeout");
         $display("bytecode_register_alu_step_test NOT OK");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // one transfer, with random leading gaps; tvalid stays up for a follow-on item
   task automatic send_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                             logic [63:0] loc);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {loc, op, a, b, c};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   // mostly legal opcodes and in-range registers, some noise
   task automatic send_random;
      logic [7:0] op, a, b, c;
      logic [63:0] loc;
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) op = 8'($urandom_range(255));
      else if (pick < 6) op = OP_EXIT;
      else begin
         case ($urandom_range(16))
            0: op = OP_LDCONST;  1: op = OP_LDLOCAL;  2: op = OP_ADD;  3: op = OP_SUB;
            4: op = OP_MUL;    5: op = OP_DIV;    6: op = OP_MOD;  7: op = OP_NOT;
            8: op = OP_AND;    9: op = OP_NAND;  10: op = OP_OR;  11: op = OP_NOR;
            12: op = OP_XOR;  13: op = OP_XNOR;  14: op = OP_SHL;
            15: op = OP_SAR;  default: op = OP_LDLOCAL;
         endcase
      end
      a = 8'(($urandom_range(99) < 5) ? $urandom_range(255) : $urandom_range(3));
      b = 8'(($urandom_range(99) < 5 || op == OP_LDCONST) ? $urandom_range(255)
                                                          : $urandom_range(3));
      c = 8'(($urandom_range(99) < 5) ? $urandom_range(255) : $urandom_range(3));
      case ($urandom_range(3))
         0: loc = rand64();
         1: loc = {{56{$urandom_range(1) == 1}}, 8'($urandom)};
         2: loc = 64'h8000_0000_0000_0000;
         default: loc = 64'($urandom_range(70));
      endcase
      send_instr(op, a, b, c, loc);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, division corner cases, illegal, bad-register and divide-by-zero errors
      send_instr(OP_LDLOCAL, 0, 0, 0, 64'h8000_0000_0000_0000);
      send_instr(OP_LDLOCAL, 1, 7, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_instr(OP_DIV,   2, 0, 1, 0);          // most negative / -1 wraps
      send_instr(OP_MOD,   3, 0, 1, 0);          // and remainder 0
      send_instr(OP_LDCONST, 3, 8'hFF, 8'hFF, 0);
      send_instr(OP_LDLOCAL, 2, 0, 0, -64'sd7);
      send_instr(OP_DIV,   1, 2, 3, 0);          // truncation toward zero
      send_instr(OP_MOD,   1, 2, 3, 0);          // sign of dividend
      send_instr(OP_LDCONST, 1, 0, 0, 0);
      send_instr(OP_DIV,   2, 3, 1, 0);          // divide by zero
      send_instr(OP_MOD,   2, 3, 1, 0);
      send_instr(OP_MUL,   2, 0, 0, 0);
      send_instr(OP_LDLOCAL, 1, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
      send_instr(OP_ADD,   2, 1, 1, 0);          // overflow wraps
      send_instr(OP_LDCONST, 3, 63, 0, 0);
      send_instr(OP_SHL,   2, 1, 3, 0);
      send_instr(OP_SAR,   2, 0, 3, 0);
      send_instr(OP_NOT,   2, 9, 8'hFF, 0);      // bad b
      send_instr(OP_ADD,   4, 0, 0, 0);          // bad a
      send_instr(OP_ADD,   0, 0, 8'hFF, 0);      // bad c
      send_instr(8'd5,     0, 0, 0, 0);          // illegal
      send_instr(8'hFF,    0, 0, 0, 0);
      drain();

      // random: long burst with no idling and a receiver hold-off
      idle_pct = 0;
      hold_off = 1;
      repeat (150) send_random();
      drain();                                   // sender pause until all results
      idle_pct = 35;
      while (sent_count < 680) send_random();
      // exit, then halted answers with arbitrary fields
      send_instr(OP_EXIT, 8'hFF, 8'hFF, 8'hFF, rand64());
      repeat (20) send_instr(8'($urandom_range(255)), 8'($urandom), 8'($urandom),
                             8'($urandom), rand64());
      drain();

      $display("sent %0d instructions, %0d results checked: all opcodes, errors, exit",
               sent_count, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("bytecode_register_alu_step_test OK");
      else
         $display("bytecode_register_alu_step_test NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
sv/brs_pkg.sv
sv/brs_serial.sv
sv/bytecode_register_alu_step.sv
tb/bytecode_register_alu_step_checker.sv
tb/bytecode_register_alu_step_test.sv
